/* src/hpt_pkg.sv */
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared widths, codes and types of the homogeneous point transform.
// ----------------------------------------------------------------------------
`default_nettype none

package hpt_pkg;

  localparam int WORD_WIDTH  = 32;
  localparam int FRAC_BITS   = 16;
  localparam int OUT_WIDTH   = 32;
  localparam int HALF_WIDTH  = 32;
  localparam int REG_WIDTH   = 64;
  localparam int NUM_REGS    = 8;
  localparam int IDX_WIDTH   = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_WIDTH  = 2;

  // exact sum of three products plus translation, with two guard bits
  localparam int ACC_WIDTH = ((2 * WORD_WIDTH > WORD_WIDTH + FRAC_BITS) ?
                              2 * WORD_WIDTH : WORD_WIDTH + FRAC_BITS) + 2;
  localparam int NUM_WIDTH = ACC_WIDTH + FRAC_BITS;
  localparam int CMP_WIDTH = ACC_WIDTH + WORD_WIDTH + FRAC_BITS;

  localparam logic [HALF_WIDTH-1:0] ONE_FIX   = HALF_WIDTH'(1) << FRAC_BITS;
  localparam logic [HALF_WIDTH-1:0] HALF_ZERO = '0;

  typedef enum logic [1:0] {
    OP_AFFINE    = 2'd0,
    OP_PROJECT   = 2'd1,
    OP_PERSP     = 2'd2,
    OP_DIRECTION = 2'd3
  } op_t;

  typedef enum logic [IDX_WIDTH-1:0] {
    REG_M11_M12, REG_M13_M14, REG_M21_M22, REG_M23_M24,
    REG_M31_M32, REG_M33_M34, REG_M41_M42, REG_M43_M44
  } reg_idx_t;

  typedef logic signed [WORD_WIDTH-1:0]   word_t;
  typedef logic signed [2*WORD_WIDTH-1:0] prod_t;
  typedef logic signed [ACC_WIDTH-1:0]    acc_t;
  typedef logic [ACC_WIDTH-1:0]           mag_t;
  typedef logic [NUM_WIDTH-1:0]           num_t;
  typedef logic [CMP_WIDTH-1:0]           cmp_t;

  typedef logic [NUM_REGS-1:0][REG_WIDTH-1:0] matrix_t;

  typedef struct packed {
    logic  transl;
    logic  divide;
    word_t x;
    word_t y;
    word_t z;
  } item_t;

  typedef struct packed {
    logic [2:0] neg;
    logic [2:0] ovf;
    logic       wz;
  } side_t;

  typedef struct packed {
    side_t                          side;
    logic [ACC_WIDTH-1:0]           d;
    logic [2:0][ACC_WIDTH-1:0]      rem;
    logic [2:0][WORD_WIDTH-1:0]     lo;
    logic [2:0][WORD_WIDTH-1:0]     q;
  } div_stage_t;

  function automatic logic [REG_WIDTH-1:0] reg_reset(input reg_idx_t idx);
    logic [REG_WIDTH-1:0] v;
    case (idx)
      REG_M11_M12, REG_M33_M34: v = {ONE_FIX, HALF_ZERO};
      REG_M21_M22, REG_M43_M44: v = {HALF_ZERO, ONE_FIX};
      default:                  v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* src/homogeneous_point_transform.sv */
// ----------------------------------------------------------------------------
// homogeneous_point_transform
// 4x4 row-vector point transform in Q16.16 with optional divide by w.
// ----------------------------------------------------------------------------
// Points enter on in_valid/in_ready with an op code and leave on
// out_valid/out_ready with the transformed coordinates and two flags.
// The matrix sits in eight 64-bit registers written through cfg_we,
// cfg_index and cfg_data; write them only while no point is in flight.
// Throughput is one point per clock while out_ready stays high. A point
// loads the input register at the accepting edge, then passes the queue,
// four arithmetic stages (products, sums, magnitudes, divider setup), 32
// divide stages at one quotient bit each, and the output register. The
// divider depth is what sets the latency. Every op runs through the same
// stages.
// While a result waits with out_ready low the whole arithmetic pipeline
// holds; the queue and the input register keep taking points until they
// fill, then in_ready drops. Reset empties the pipeline and loads the
// identity matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module homogeneous_point_transform (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire logic [1:0]                              op,
  input  wire logic [31:0]                             in_x,
  input  wire logic [31:0]                             in_y,
  input  wire logic [31:0]                             in_z,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic [31:0]                                  res_x,
  output logic [31:0]                                  res_y,
  output logic [31:0]                                  res_z,
  output logic                                         w_zero,
  output logic                                         saturated,
  input  wire logic                                    cfg_we,
  input  wire logic [hpt_pkg::IDX_WIDTH-1:0]           cfg_index,
  input  wire logic [hpt_pkg::REG_WIDTH-1:0]           cfg_data
);

  hpt_pkg::matrix_t matrix;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < hpt_pkg::NUM_REGS; i++) begin
        matrix[i] <= hpt_pkg::reg_reset(hpt_pkg::reg_idx_t'(hpt_pkg::IDX_WIDTH'(i)));
      end
    end else if (cfg_we) begin
      matrix[cfg_index] <= cfg_data;
    end
  end

  logic           push_valid;
  logic           push_ready;
  hpt_pkg::item_t push_item;
  logic           pop_valid;
  logic           pop_ready;
  hpt_pkg::item_t pop_item;

  hpt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .in_x       (in_x),
    .in_y       (in_y),
    .in_z       (in_z),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  hpt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  hpt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .matrix    (matrix),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_x     (res_x),
    .res_y     (res_y),
    .res_z     (res_z),
    .w_zero    (w_zero),
    .saturated (saturated)
  );

  a_zero_w_not_saturated : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(w_zero && saturated))
    else $error("zero w result also flagged saturated");

  a_zero_w_clears_results : assert property (@(posedge clk) disable iff (rst)
    (out_valid && w_zero) |-> (res_x == '0 && res_y == '0 && res_z == '0))
    else $error("zero w result carries nonzero coordinates");

  a_stall_holds_result : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(res_x) && $stable(saturated)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

/* src/hpt_front.sv */
// ----------------------------------------------------------------------------
// hpt_front
// Input register: accepts points and decodes the op into path flags.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_front (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         op,
  input  wire logic [31:0]                        in_x,
  input  wire logic [31:0]                        in_y,
  input  wire logic [31:0]                        in_z,
  output logic                                    push_valid,
  input  wire logic                               push_ready,
  output hpt_pkg::item_t                          push_item
);

  logic           valid;
  hpt_pkg::item_t item;
  hpt_pkg::item_t item_next;

  assign in_ready   = !valid || push_ready;
  assign push_valid = valid;
  assign push_item  = item;

  always_comb begin
    item_next   = '0;
    item_next.x = in_x[hpt_pkg::WORD_WIDTH-1:0];
    item_next.y = in_y[hpt_pkg::WORD_WIDTH-1:0];
    item_next.z = in_z[hpt_pkg::WORD_WIDTH-1:0];
    case (hpt_pkg::op_t'(op))
      hpt_pkg::OP_AFFINE: begin
        item_next.transl = 1'b1;
        item_next.divide = 1'b0;
      end
      hpt_pkg::OP_PROJECT: begin
        item_next.transl = 1'b1;
        item_next.divide = 1'b1;
      end
      hpt_pkg::OP_PERSP: begin
        item_next.transl = 1'b0;
        item_next.divide = 1'b1;
      end
      default: begin
        item_next.transl = 1'b0;
        item_next.divide = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

/* src/hpt_queue.sv */
// ----------------------------------------------------------------------------
// hpt_queue
// Short FIFO between the decode front and the arithmetic back.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire hpt_pkg::item_t push_item,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output hpt_pkg::item_t      pop_item
);

  hpt_pkg::item_t                    entries [hpt_pkg::QUEUE_DEPTH];
  logic [hpt_pkg::QPTR_WIDTH-1:0]    wptr;
  logic [hpt_pkg::QPTR_WIDTH-1:0]    rptr;
  logic [hpt_pkg::QPTR_WIDTH:0]      count;
  logic                              push;
  logic                              pop;

  assign push_ready = (count != (hpt_pkg::QPTR_WIDTH+1)'(hpt_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

/* src/hpt_div.sv */
// ----------------------------------------------------------------------------
// hpt_div
// Pipelined restoring divider: three lanes, shared divisor, one bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire hpt_pkg::div_stage_t in_stage,
  output logic                    out_valid,
  output hpt_pkg::div_stage_t     out_stage
);

  localparam int W  = hpt_pkg::WORD_WIDTH;
  localparam int AW = hpt_pkg::ACC_WIDTH;

  hpt_pkg::div_stage_t st [W+1];
  logic                v  [W+1];

  assign st[0]     = in_stage;
  assign v[0]      = in_valid;
  assign out_stage = st[W];
  assign out_valid = v[W];

  for (genvar k = 0; k < W; k++) begin : g_step
    hpt_pkg::div_stage_t nxt;
    logic [AW:0]         trial [3];

    always_comb begin
      nxt = st[k];
      for (int l = 0; l < 3; l++) begin
        // bring down the next numerator bit
        trial[l] = {st[k].rem[l], st[k].lo[l][W-1]};
        nxt.lo[l] = st[k].lo[l] << 1;
        if (trial[l] >= {1'b0, st[k].d}) begin
          nxt.rem[l] = AW'(trial[l] - {1'b0, st[k].d});
          nxt.q[l]   = {st[k].q[l][W-2:0], 1'b1};
        end else begin
          nxt.rem[l] = AW'(trial[l]);
          nxt.q[l]   = {st[k].q[l][W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1] <= nxt;
      end
    end
  end

endmodule

`default_nettype wire

/* src/hpt_back.sv */
// ----------------------------------------------------------------------------
// hpt_back
// Arithmetic pipeline: products, sums, magnitudes, divide, clamp, output.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire hpt_pkg::matrix_t matrix,
  input  wire logic             pop_valid,
  output logic                  pop_ready,
  input  wire hpt_pkg::item_t   pop_item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [31:0]           res_x,
  output logic [31:0]           res_y,
  output logic [31:0]           res_z,
  output logic                  w_zero,
  output logic                  saturated
);

  localparam int W  = hpt_pkg::WORD_WIDTH;
  localparam int F  = hpt_pkg::FRAC_BITS;
  localparam int AW = hpt_pkg::ACC_WIDTH;
  localparam int HW = hpt_pkg::HALF_WIDTH;
  localparam logic [W-1:0] LIM = {1'b1, {(W-1){1'b0}}};

  function automatic hpt_pkg::word_t coef(input hpt_pkg::matrix_t m, input int r,
                                          input int c);
    logic [hpt_pkg::REG_WIDTH-1:0] rv;
    rv = m[(r << 1) | (c >> 1)];
    if ((c & 1) != 0) begin
      return rv[W-1:0];
    end
    return rv[HW+W-1:HW];
  endfunction

  logic en;
  assign en        = !out_valid || out_ready;
  assign pop_ready = en;

  // stage 1: products and translation terms
  logic           v1;
  logic           s1_div;
  hpt_pkg::prod_t s1_prod  [4][3];
  hpt_pkg::acc_t  s1_trans [4];
  hpt_pkg::word_t pw [3];

  assign pw[0] = pop_item.x;
  assign pw[1] = pop_item.y;
  assign pw[2] = pop_item.z;

  // stage 2: exact sums
  logic           v2;
  logic           s2_div;
  hpt_pkg::acc_t  s2_acc [4];

  // stage 3: magnitudes and signs
  logic           v3;
  logic           s3_div;
  logic           s3_wz;
  logic [2:0]     s3_neg;
  hpt_pkg::mag_t  s3_mag [3];
  hpt_pkg::mag_t  s3_d;

  // stage 4: divider setup
  logic                v4;
  hpt_pkg::div_stage_t s4;
  hpt_pkg::div_stage_t s4_next;
  hpt_pkg::num_t       num [3];

  logic                dv_valid;
  hpt_pkg::div_stage_t dv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= pop_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_div <= pop_item.divide;
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 3; r++) begin
          s1_prod[c][r] <= hpt_pkg::prod_t'(pw[r]) *
                           hpt_pkg::prod_t'(coef(matrix, r, c));
        end
        s1_trans[c] <= pop_item.transl ?
                       (hpt_pkg::acc_t'(coef(matrix, 3, c)) <<< F) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_div <= s1_div;
      for (int c = 0; c < 4; c++) begin
        s2_acc[c] <= hpt_pkg::acc_t'(s1_prod[c][0]) + hpt_pkg::acc_t'(s1_prod[c][1]) +
                     hpt_pkg::acc_t'(s1_prod[c][2]) + s1_trans[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_div <= s2_div;
      s3_wz  <= s2_div && (s2_acc[3] == '0);
      for (int c = 0; c < 3; c++) begin
        s3_mag[c] <= s2_acc[c][AW-1] ? hpt_pkg::mag_t'(-s2_acc[c])
                                     : hpt_pkg::mag_t'(s2_acc[c]);
        s3_neg[c] <= s2_acc[c][AW-1] ^ (s2_div && s2_acc[3][AW-1]);
      end
      // without a divide, dividing by one passes the truncated value through
      s3_d <= s2_div ? (s2_acc[3][AW-1] ? hpt_pkg::mag_t'(-s2_acc[3])
                                        : hpt_pkg::mag_t'(s2_acc[3]))
                     : hpt_pkg::mag_t'(1);
    end
  end

  always_comb begin
    s4_next          = '0;
    s4_next.d        = s3_d;
    s4_next.side.neg = s3_neg;
    s4_next.side.wz  = s3_wz;
    for (int l = 0; l < 3; l++) begin
      num[l] = s3_div ? (hpt_pkg::num_t'(s3_mag[l]) << F)
                      : hpt_pkg::num_t'(s3_mag[l] >> F);
      // quotient needs more than W bits: clamp regardless
      s4_next.side.ovf[l] = hpt_pkg::cmp_t'(num[l]) >= (hpt_pkg::cmp_t'(s3_d) << W);
      s4_next.rem[l]      = AW'(num[l] >> W);
      s4_next.lo[l]       = num[l][W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4 <= s4_next;
    end
  end

  hpt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .in_stage  (s4),
    .out_valid (dv_valid),
    .out_stage (dv)
  );

  // clamp to the signed word range
  logic [W-1:0] val [3];
  logic [2:0]   sat;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      sat[l] = 1'b0;
      if (dv.side.wz) begin
        val[l] = '0;
      end else if (dv.side.neg[l]) begin
        if (dv.side.ovf[l] || (dv.q[l] > LIM)) begin
          val[l] = LIM;
          sat[l] = 1'b1;
        end else begin
          val[l] = -dv.q[l];
        end
      end else begin
        if (dv.side.ovf[l] || (dv.q[l] > LIM - 1'b1)) begin
          val[l] = LIM - 1'b1;
          sat[l] = 1'b1;
        end else begin
          val[l] = dv.q[l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_x     <= hpt_pkg::OUT_WIDTH'($signed(val[0]));
      res_y     <= hpt_pkg::OUT_WIDTH'($signed(val[1]));
      res_z     <= hpt_pkg::OUT_WIDTH'($signed(val[2]));
      w_zero    <= dv.side.wz;
      saturated <= |sat;
    end
  end

endmodule

`default_nettype wire
